### hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

	localparam int TW_W   = 8;   // trigger width register
	localparam int GAP_W  = 16;  // gap register, phase timer
	localparam int CNT_W  = 16;  // echo count
	localparam int SUM_W  = 19;  // echo sum
	localparam int IDX_W  = 3;   // sample index
	localparam int DIST_W = 15;  // distance, 1/16 cm

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAP        = CFG_IDX_W'(1);

	localparam logic [TW_W-1:0]   TRIG_WIDTH_RST = TW_W'(20);
	localparam logic [GAP_W-1:0]  GAP_RST        = GAP_W'(50000);

	// one result beat
	typedef struct packed {
		logic              trigger_level;
		logic              busy_res;
		logic              done_res;
		logic [DIST_W-1:0] distance_q4;
	} uer_res_t;

endpackage

### hdl/uer_scale.sv
// Echo sum to averaged distance: constant divide by reciprocal multiply.
module uer_scale #(
	parameter int SAMPLES = 5
) (
	input  logic [uer_pkg::SUM_W-1:0]  sum,
	output logic [uer_pkg::DIST_W-1:0] distance
);
	import uer_pkg::*;

	// distance = 16*sum/(58*S) = 8*sum/(29*S); numerator is NUM_W bits wide
	localparam int NUM_W = SUM_W + 3;
	localparam int DIV   = 29 * SAMPLES;
	localparam int SH    = NUM_W + $clog2(DIV);
	localparam longint unsigned MUL_L = ((64'd1 << SH) / DIV) + 64'd1;
	localparam int MUL_W = NUM_W + 1;
	localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_L);

	logic [NUM_W-1:0]       num;
	logic [NUM_W+MUL_W-1:0] prod;

	// exact for every numerator below 2**NUM_W since DIV is never a power of two
	assign num      = {sum, 3'b000};
	assign prod     = (NUM_W+MUL_W)'(num) * (NUM_W+MUL_W)'(MUL);
	assign distance = prod[SH +: DIST_W];

endmodule

### hdl/uer_core.sv
// Ranging sequencer: phase state, timers, echo count and sum, distance.
module uer_core #(
	parameter int SAMPLES = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step_en,
	input  logic                      start_req,
	input  logic                      echo_level,
	input  logic [uer_pkg::TW_W-1:0]  trig_width,
	input  logic [uer_pkg::GAP_W-1:0] gap,
	output uer_pkg::uer_res_t         res
);
	import uer_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TRIG  = 3'd1,
		PH_WAIT  = 3'd2,
		PH_COUNT = 3'd3,
		PH_GAP   = 3'd4
	} phase_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

	phase_t            phase_q, phase_d;
	logic [GAP_W-1:0]  timer_q, timer_d, timer_inc;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [DIST_W-1:0] dist_q, dist_d, dist_calc;
	logic [TW_W-1:0]   width_ticks;
	phase_t            trig_first;
	logic              trig, done;

	// sum is settled for at least one beat before the finish reads it
	uer_scale #(.SAMPLES(SAMPLES)) u_scale (
		.sum      (sum_q),
		.distance (dist_calc)
	);

	assign width_ticks = (trig_width == '0) ? TW_W'(1) : trig_width;
	assign timer_inc   = timer_q + GAP_W'(1);
	// first trigger tick counts as one
	assign trig_first  = (width_ticks == TW_W'(1)) ? PH_WAIT : PH_TRIG;

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		count_d = count_q;
		sum_d   = sum_q;
		idx_d   = idx_q;
		dist_d  = dist_q;
		trig    = 1'b0;
		done    = 1'b0;
		unique case (phase_q)
			PH_TRIG: begin
				trig    = 1'b1;
				timer_d = timer_inc;
				if (timer_inc >= GAP_W'(width_ticks))
					phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				if (echo_level) begin
					count_d = CNT_W'(1);
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (echo_level) begin
					if (count_q != '1)
						count_d = count_q + CNT_W'(1);
				end else begin
					sum_d   = sum_q + SUM_W'(count_q);
					timer_d = '0;
					phase_d = PH_GAP;
				end
			end
			PH_GAP: begin
				if (timer_q >= gap) begin
					if (idx_q >= LAST_IDX) begin
						dist_d  = dist_calc;
						done    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						trig    = 1'b1;
						timer_d = GAP_W'(1);
						phase_d = trig_first;
					end
				end else begin
					timer_d = timer_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (start_req) begin
					sum_d   = '0;
					count_d = '0;
					idx_d   = '0;
					trig    = 1'b1;
					timer_d = GAP_W'(1);
					phase_d = trig_first;
				end
			end
		endcase
	end

	always_comb begin
		res.trigger_level = trig;
		res.busy_res      = (phase_d != PH_IDLE);
		res.done_res      = done;
		res.distance_q4   = dist_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			count_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			dist_q  <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			idx_q   <= idx_d;
			dist_q  <= dist_d;
		end
	end

endmodule

### hdl/ultrasonic_echo_ranger.sv
// Top level: input register, sequencer, result register, config registers.
//
//  channel  | direction | handshake          | payload
//  s_axis   | in        | s_tvalid/s_tready  | s_tdata: start_req, echo_level
//  m_axis   | out       | m_tvalid/m_tready  | m_tdata: trigger, busy, done, distance
//  cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One result beat per input beat; an input beat passes the input register, then the result
// register, on its way to m_tdata.
// Sustains one beat per cycle unless m_tready stalls: one sequencer pass per beat.
// Reset clears the sequencer to idle, config to 20 / 50000, both registers empty.
// A stalled m_tready holds the result; the input register fills, then s_tready drops.
module ultrasonic_echo_ranger #(
	parameter int SAMPLES = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [uer_pkg::IN_DATA_W-1:0]      s_tdata,   // [0] start_req, [1] echo_level
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [uer_pkg::OUT_DATA_W-1:0]     m_tdata,   // [0] trigger_level, [1] busy_res,
	                                                      // [2] done_res, [17:3] distance_q4
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import uer_pkg::*;

	logic             valid_s1, start_s1, echo_s1;
	logic             step;
	logic             out_valid_q;
	uer_res_t         res, out_q;
	logic [TW_W-1:0]  trig_width_q;
	logic [GAP_W-1:0] gap_q;

	assign step      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			start_s1 <= s_tdata[0];
			echo_s1  <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_width_q <= TRIG_WIDTH_RST;
			gap_q        <= GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_TRIG_WIDTH)
				trig_width_q <= cfg_data[TW_W-1:0];
			else if (cfg_index == REG_GAP)
				gap_q <= cfg_data[GAP_W-1:0];
		end
	end

	uer_core #(.SAMPLES(SAMPLES)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step),
		.start_req  (start_s1),
		.echo_level (echo_s1),
		.trig_width (trig_width_q),
		.gap        (gap_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W-DIST_W-3)'(0), out_q.distance_q4,
		out_q.done_res, out_q.busy_res, out_q.trigger_level};

endmodule

### hdl/uer_checker.sv
// Port-level checks for the echo ranger, bound to the top level.
module uer_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [uer_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import uer_pkg::*;

	// held result beat must not change under back-pressure
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// finishing beat already reports idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[1])
		else $error("done reported while busy");

	// trigger is only driven inside a running sequence
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("trigger high while idle");

	// averaged distance never exceeds a saturated echo
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:3] <= 15'd18079)
		else $error("distance out of range");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ultrasonic echo ranger: stream stimulus, predictor, scoreboard.
module tb;
	import uer_pkg::*;

	localparam int SAMPLES   = 5;
	localparam int DIST_LSB  = 3;   // distance_q4 sits above trigger, busy, done
	localparam int SETTLE    = 8;   // cycles after the last beat, two-stage pipe plus margin
	localparam int RAND_TICKS = 200;

	typedef enum logic [2:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_COUNT, PH_GAP} seq_phase_t;
	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} tick_t;

	// Cycle-level copy of the sequencer, one call per microsecond tick.
	class ranger_model;
		logic [TW_W-1:0]   trig_width;
		logic [GAP_W-1:0]  gap_len;
		seq_phase_t        ph;
		logic [GAP_W-1:0]  timer;
		logic [CNT_W-1:0]  echo_cnt;
		logic [SUM_W-1:0]  echo_sum;
		logic [IDX_W-1:0]  sample_idx;
		logic [DIST_W-1:0] distance;

		function new();
			trig_width = TRIG_WIDTH_RST;
			gap_len    = GAP_RST;
			ph         = PH_IDLE;
			timer      = '0;
			echo_cnt   = '0;
			echo_sum   = '0;
			sample_idx = '0;
			distance   = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_TRIG_WIDTH)
				trig_width = data[TW_W-1:0];
			else if (idx == REG_GAP)
				gap_len = data;
		endfunction

		function bit busy();
			return ph != PH_IDLE;
		endfunction

		// first trigger-high tick of a ranging cycle
		function void open_trigger(logic [TW_W-1:0] w);
			timer = GAP_W'(1);
			ph = (timer >= GAP_W'(w)) ? PH_WAIT : PH_TRIG;
		endfunction

		function uer_res_t advance_tick(logic start, logic echo);
			uer_res_t r;
			logic [TW_W-1:0] w;
			logic trig;
			logic done;
			trig = 1'b0;
			done = 1'b0;
			w = (trig_width == '0) ? TW_W'(1) : trig_width;
			case (ph)
				PH_TRIG: begin
					trig = 1'b1;
					timer = timer + GAP_W'(1);
					if (timer >= GAP_W'(w))
						ph = PH_WAIT;
				end
				PH_WAIT: begin
					if (echo) begin
						echo_cnt = CNT_W'(1);
						ph = PH_COUNT;
					end
				end
				PH_COUNT: begin
					if (echo) begin
						if (echo_cnt != '1)
							echo_cnt = echo_cnt + CNT_W'(1);
					end else begin
						echo_sum = echo_sum + SUM_W'(echo_cnt);
						timer = '0;
						ph = PH_GAP;
					end
				end
				PH_GAP: begin
					if (timer >= gap_len) begin
						if (int'(sample_idx) >= SAMPLES - 1) begin
							distance = DIST_W'((32'(echo_sum) * 32'd16) / (32'd58 * SAMPLES));
							done = 1'b1;
							ph = PH_IDLE;
						end else begin
							sample_idx = sample_idx + IDX_W'(1);
							trig = 1'b1;
							open_trigger(w);
						end
					end else begin
						timer = timer + GAP_W'(1);
					end
				end
				default: begin
					ph = PH_IDLE;
					if (start) begin
						echo_sum   = '0;
						echo_cnt   = '0;
						sample_idx = '0;
						trig = 1'b1;
						open_trigger(w);
					end
				end
			endcase
			r.trigger_level = trig;
			r.busy_res      = (ph != PH_IDLE);
			r.done_res      = done;
			r.distance_q4   = distance;
			return r;
		endfunction
	endclass

	class echo_scoreboard;
		ranger_model mdl;
		uer_res_t    expected_beats[$];
		int          mismatches;
		int          beat_no;

		function new();
			mdl = new();
			mismatches = 0;
			beat_no = 0;
		endfunction

		function void note_tick(logic start, logic echo);
			expected_beats.push_back(mdl.advance_tick(start, echo));
		endfunction

		task report(string what);
			if (mismatches < 50)
				$display("[%0t] beat %0d: %s", $time, beat_no, what);
			mismatches++;
		endtask

		task check_beat(logic [OUT_DATA_W-1:0] beat);
			uer_res_t want;
			if (expected_beats.size() == 0) begin
				report("result beat with nothing predicted");
				beat_no++;
				return;
			end
			want = expected_beats.pop_front();
			if (beat[0] !== want.trigger_level)
				report($sformatf("trigger_level %b, want %b", beat[0], want.trigger_level));
			if (beat[1] !== want.busy_res)
				report($sformatf("busy_res %b, want %b", beat[1], want.busy_res));
			if (beat[2] !== want.done_res)
				report($sformatf("done_res %b, want %b", beat[2], want.done_res));
			if (beat[DIST_LSB +: DIST_W] !== want.distance_q4)
				report($sformatf("distance_q4 %0d, want %0d",
					beat[DIST_LSB +: DIST_W], want.distance_q4));
			beat_no++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;     // [0] start_req, [1] echo_level
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // [0] trigger, [1] busy, [2] done, [17:3] distance
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	echo_scoreboard sb;
	ranger_model    planner;     // tracks the stimulus as it is generated
	tick_t          stim_q[$];
	int             planned = 0;
	int             hold_cycles = 0;
	int             mode_left = 0;
	int             rx_cyc = 0;
	rx_mode_t       rx_mode = RX_OPEN;

	ultrasonic_echo_ranger #(.SAMPLES(SAMPLES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: checks every beat, stalls on its own pattern, long hold-off on request
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_beat(m_tdata);
		rx_cyc++;
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN:  m_tready <= 1'b1;
				RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: m_tready <= ($urandom_range(0, 1) != 0);
				default:  m_tready <= ((rx_cyc % 9) < 6);
			endcase
		end
	end

	function automatic void push_item(logic st, logic ec);
		tick_t t;
		t.start_req  = st;
		t.echo_level = ec;
		stim_q.push_back(t);
		void'(planner.advance_tick(st, ec));
		planned++;
	endfunction

	// well-formed measurement; partial stops once the first gap is entered
	task automatic plan_measurement(int max_wait, int max_echo, int start_pct,
	                                int first_echo, bit partial);
		int   wait_left;
		int   high_left;
		logic st;
		logic ec;
		push_item(1'b1, 1'($urandom_range(0, 1)));
		wait_left = $urandom_range(0, max_wait);
		high_left = (first_echo > 0) ? first_echo : $urandom_range(1, max_echo);
		while (planner.busy() && !(partial && planner.ph == PH_GAP)) begin
			st = ($urandom_range(0, 99) < start_pct);
			case (planner.ph)
				PH_WAIT: begin
					if (wait_left > 0) begin
						ec = 1'b0;
						wait_left--;
					end else begin
						ec = 1'b1;
					end
				end
				PH_COUNT: begin
					if (high_left > 1) begin
						ec = 1'b1;
						high_left--;
					end else begin
						ec = 1'b0;
						wait_left = $urandom_range(0, max_wait);
						high_left = $urandom_range(1, max_echo);
					end
				end
				default: ec = 1'($urandom_range(0, 1));
			endcase
			push_item(st, ec);
		end
	endtask

	// finish whatever noise left running, with ragged echoes
	task automatic plan_drain();
		logic ec;
		while (planner.busy()) begin
			case (planner.ph)
				PH_WAIT:  ec = ($urandom_range(0, 2) == 0);
				PH_COUNT: ec = ($urandom_range(0, 3) != 0);
				default:  ec = 1'($urandom_range(0, 1));
			endcase
			push_item(1'($urandom_range(0, 1)), ec);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.mdl.write_reg(idx, data);
		planner.write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// sender: bursts of beats with random gaps, each beat held until taken
	task automatic send_all();
		int    burst;
		int    idle;
		tick_t t;
		@(posedge clk);
		while (stim_q.size() > 0) begin
			burst = $urandom_range(1, 48);
			while (burst > 0 && stim_q.size() > 0) begin
				t = stim_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= IN_DATA_W'({t.echo_level, t.start_req});
				@(posedge clk);
				while (!s_tready)
					@(posedge clk);
				sb.note_tick(t.start_req, t.echo_level);
				burst--;
			end
			idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (idle > 0 || stim_q.size() == 0) begin
				s_tvalid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
	endtask

	task automatic run_phase();
		send_all();
		while (sb.expected_beats.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(logic [TW_W-1:0] tw, logic [GAP_W-1:0] gap, int hold);
		int base;
		write_reg(REG_TRIG_WIDTH, {8'($urandom_range(0, 255)), tw});
		write_reg(REG_GAP, gap);
		base = planned;
		while (planned - base < RAND_TICKS) begin
			if ($urandom_range(0, 4) != 0) begin
				repeat ($urandom_range(0, 3)) push_item(1'b0, 1'($urandom_range(0, 1)));
				plan_measurement(6, 40, 10, 0, 1'b0);
			end else begin
				repeat ($urandom_range(3, 25))
					push_item(($urandom_range(0, 99) < 15), 1'($urandom_range(0, 1)));
				plan_drain();
			end
		end
		hold_cycles = hold;
		run_phase();
	endtask

	initial begin
		sb = new();
		planner = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset: idle beats, distance still zero
		repeat (4) push_item(1'b0, 1'($urandom_range(0, 1)));
		run_phase();

		// zero width, zero gap, writes to unmapped indexes
		write_reg(REG_TRIG_WIDTH, '0);
		write_reg(REG_GAP, '0);
		write_reg(CFG_IDX_W'(2), 16'hFFFF);
		write_reg(CFG_IDX_W'(255), 16'h1234);
		// start held high throughout: ignored while busy and on the finishing tick
		plan_measurement(1, 2, 100, 0, 1'b0);
		push_item(1'b1, 1'b1);
		push_item(1'b0, 1'b0);
		run_phase();

		random_phase(TW_W'(20), GAP_W'(7), 0);
		random_phase(TW_W'(1), GAP_W'(0), 0);
		random_phase(TW_W'($urandom_range(2, 9)), GAP_W'($urandom_range(0, 25)), 400);
		random_phase(TW_W'(0), GAP_W'(1), 0);

		// widest trigger, longest gap: run into the gap and stop there
		write_reg(REG_TRIG_WIDTH, CFG_DATA_W'(255));
		write_reg(REG_GAP, 16'hFFFF);
		plan_measurement(5, 30, 5, 0, 1'b1);
		repeat (100) push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		run_phase();

		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
hdl/uer_pkg.sv
hdl/uer_scale.sv
hdl/uer_core.sv
hdl/ultrasonic_echo_ranger.sv
hdl/uer_checker.sv
tb/tb.sv
